[rtl/core/json_answer_string_decoder_assert.svh]
// assertion macros of the decoder, used by the result register module
`ifndef JSON_ANSWER_STRING_DECODER_ASSERT_SVH
`define JSON_ANSWER_STRING_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check that cons holds in the same cycle as ante
`define JASD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jasd check failed");
// check that cons holds in the cycle after ante
`define JASD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jasd check failed");
`else
`define JASD_ASSERT_NOW(lbl, ante, cons)
`define JASD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/jasd_pkg.sv]
// types, constants and helper functions of the answer string decoder
`timescale 1ns / 1ps

package jasd_pkg;

  localparam int MaxRes = 4;

  typedef enum logic [3:0] {
    PH_SEARCH  = 4'd0,
    PH_COLON   = 4'd1,
    PH_QUOTE   = 4'd2,
    PH_VALUE   = 4'd3,
    PH_ESC     = 4'd4,
    PH_HEX1    = 4'd5,
    PH_PAIR_BS = 4'd6,
    PH_PAIR_U  = 4'd7,
    PH_HEX2    = 4'd8,
    PH_DONE    = 4'd9,
    PH_ERROR   = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OPEN = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // quoted key text, quotes included
  localparam logic [7:0] KEY_TEXT [8] = '{
    8'h22, 8'h61, 8'h6E, 8'h73, 8'h77, 8'h65, 8'h72, 8'h22
  };

  // surrogate ranges
  localparam logic [15:0] HI_SUR_LO = 16'hD800;
  localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SUR_LO = 16'hDC00;
  localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
  localparam logic [20:0] SUP_BASE  = 21'h10000;

  // results caused by one input item
  typedef struct packed {
    logic [2:0]        cnt;
    kind_t             kind;
    logic [3:0][7:0]   data;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // case-insensitive hex digit
  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t       h;
    logic [7:0] up;
    up = b & 8'hDF;
    h  = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = b[3:0];
    end else if (up >= 8'h41 && up <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = b[3:0] + 4'd9;
    end
    return h;
  endfunction

  // code point to utf-8 byte sequence, first byte in slot 0
  function automatic bundle_t utf8_enc(input logic [20:0] cp);
    bundle_t r;
    r      = '0;
    r.kind = KIND_DATA;
    if (cp[20:7] == '0) begin
      r.cnt     = 3'd1;
      r.data[0] = {1'b0, cp[6:0]};
    end else if (cp[20:11] == '0) begin
      r.cnt     = 3'd2;
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      r.cnt     = 3'd3;
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt     = 3'd4;
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[rtl/core/jasd_decode.sv]
// parser state and single-pass decode of one item into a result bundle
`timescale 1ns / 1ps

module jasd_decode import jasd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv_i,
  input  logic [7:0] byte_i,
  input  logic       new_reply_i,
  output bundle_t    bundle_o
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  km_r, km_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [9:0]  hu_r, hu_nxt;
  logic [15:0] ua_r, ua_nxt;

  phase_t      ph_cur;
  logic [2:0]  km_cur;
  logic [1:0]  hc_cur;
  logic [9:0]  hu_cur;
  logic [15:0] ua_cur;
  hex_t        hx;
  logic [15:0] unit_new;
  logic [20:0] cp_pair;
  bundle_t     bnd;

  // new reply flag clears state before the byte is handled
  always_comb begin
    ph_cur = new_reply_i ? PH_SEARCH : phase_r;
    km_cur = new_reply_i ? 3'd0 : km_r;
    hc_cur = new_reply_i ? 2'd0 : hc_r;
    hu_cur = new_reply_i ? 10'd0 : hu_r;
    ua_cur = new_reply_i ? 16'd0 : ua_r;
  end

  assign hx       = hex_digit(byte_i);
  assign unit_new = {ua_cur[11:0], hx.val};
  assign cp_pair  = SUP_BASE + {1'b0, hu_cur, unit_new[9:0]};

  // next state and results
  always_comb begin
    phase_nxt = ph_cur;
    km_nxt    = km_cur;
    hc_nxt    = hc_cur;
    hu_nxt    = hu_cur;
    ua_nxt    = ua_cur;
    bnd       = '0;
    bnd.kind  = KIND_DATA;
    unique case (ph_cur)
      PH_SEARCH: begin
        if (byte_i == KEY_TEXT[km_cur]) begin
          if (km_cur == 3'd7) begin
            km_nxt    = 3'd0;
            phase_nxt = PH_COLON;
          end else begin
            km_nxt = km_cur + 3'd1;
          end
        end else begin
          km_nxt = (byte_i == CH_QUOTE) ? 3'd1 : 3'd0;
        end
      end
      PH_COLON: begin
        if (byte_i == CH_COLON) begin
          phase_nxt = PH_QUOTE;
        end else if (!is_ws(byte_i)) begin
          bnd.kind  = KIND_ERR;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_ERROR;
        end
      end
      PH_QUOTE: begin
        if (byte_i == CH_QUOTE) begin
          bnd.kind  = KIND_OPEN;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_VALUE;
        end else if (!is_ws(byte_i)) begin
          bnd.kind  = KIND_ERR;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_ERROR;
        end
      end
      PH_VALUE: begin
        if (byte_i == CH_QUOTE) begin
          bnd.kind  = KIND_DONE;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_DONE;
        end else if (byte_i == CH_BSL) begin
          phase_nxt = PH_ESC;
        end else if (byte_i < CH_SPACE) begin
          bnd.kind  = KIND_ERR;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_ERROR;
        end else begin
          bnd.cnt     = 3'd1;
          bnd.data[0] = byte_i;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_VALUE;
        bnd.cnt   = 3'd1;
        if (byte_i == CH_QUOTE || byte_i == CH_BSL || byte_i == CH_SLASH) begin
          bnd.data[0] = byte_i;
        end else if (byte_i == CH_B || byte_i == CH_F) begin
          bnd.data[0] = CH_SPACE;
        end else if (byte_i == CH_N) begin
          bnd.data[0] = CH_LF;
        end else if (byte_i == CH_R) begin
          bnd.data[0] = CH_CR;
        end else if (byte_i == CH_T) begin
          bnd.data[0] = CH_TAB;
        end else if (byte_i == CH_U) begin
          bnd.cnt   = 3'd0;
          hc_nxt    = 2'd0;
          ua_nxt    = 16'd0;
          phase_nxt = PH_HEX1;
        end else begin
          bnd.kind  = KIND_ERR;
          phase_nxt = PH_ERROR;
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (!hx.ok) begin
          bnd.kind  = KIND_ERR;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_ERROR;
        end else begin
          ua_nxt = unit_new;
          if (hc_cur != 2'd3) begin
            hc_nxt = hc_cur + 2'd1;
          end else begin
            hc_nxt = 2'd0;
            if (ph_cur == PH_HEX1) begin
              if (unit_new >= HI_SUR_LO && unit_new <= HI_SUR_HI) begin
                hu_nxt    = unit_new[9:0];
                phase_nxt = PH_PAIR_BS;
              end else if (unit_new >= LO_SUR_LO && unit_new <= LO_SUR_HI) begin
                bnd.kind  = KIND_ERR;
                bnd.cnt   = 3'd1;
                phase_nxt = PH_ERROR;
              end else begin
                bnd       = utf8_enc({5'd0, unit_new});
                phase_nxt = PH_VALUE;
              end
            end else begin
              if (unit_new < LO_SUR_LO || unit_new > LO_SUR_HI) begin
                bnd.kind  = KIND_ERR;
                bnd.cnt   = 3'd1;
                phase_nxt = PH_ERROR;
              end else begin
                bnd       = utf8_enc(cp_pair);
                phase_nxt = PH_VALUE;
              end
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (byte_i == CH_BSL) begin
          phase_nxt = PH_PAIR_U;
        end else begin
          bnd.kind  = KIND_ERR;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_ERROR;
        end
      end
      PH_PAIR_U: begin
        if (byte_i == CH_U) begin
          hc_nxt    = 2'd0;
          ua_nxt    = 16'd0;
          phase_nxt = PH_HEX2;
        end else begin
          bnd.kind  = KIND_ERR;
          bnd.cnt   = 3'd1;
          phase_nxt = PH_ERROR;
        end
      end
      default: begin
      end
    endcase
  end

  assign bundle_o = bnd;

  // parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      km_r    <= 3'd0;
      hc_r    <= 2'd0;
      hu_r    <= 10'd0;
      ua_r    <= 16'd0;
    end else if (adv_i) begin
      phase_r <= phase_nxt;
      km_r    <= km_nxt;
      hc_r    <= hc_nxt;
      hu_r    <= hu_nxt;
      ua_r    <= ua_nxt;
    end
  end

endmodule

[rtl/core/jasd_out_buf.sv]
// result register that hands out a bundle one item per cycle while out_ready is high
`timescale 1ns / 1ps

`include "json_answer_string_decoder_assert.svh"

module jasd_out_buf import jasd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  bundle_t    bundle_i,
  output logic       buf_ready_o,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  logic [2:0]      rem_r, rem_nxt;
  logic [1:0]      pos_r, pos_nxt;
  kind_t           kind_r;
  logic [3:0][7:0] data_r;
  logic            take;

  assign out_valid       = (rem_r != 3'd0);
  assign take            = out_valid && out_ready;
  assign buf_ready_o     = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ready);
  assign out_result_kind = kind_r;
  assign out_byte        = data_r[pos_r];
  assign out_last_of_run = (rem_r == 3'd1);

  // count and position of the item on show
  always_comb begin
    rem_nxt = rem_r;
    pos_nxt = pos_r;
    if (load_i) begin
      rem_nxt = bundle_i.cnt;
      pos_nxt = 2'd0;
    end else if (take) begin
      rem_nxt = rem_r - 3'd1;
      pos_nxt = pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      pos_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      pos_r <= pos_nxt;
    end
  end

  // payload of the bundle
  always_ff @(posedge clk) begin
    if (load_i) begin
      kind_r <= bundle_i.kind;
      data_r <= bundle_i.data;
    end
  end

  `JASD_ASSERT_NOW(a_rem_bound, 1'b1, rem_r <= 3'(MaxRes))
  `JASD_ASSERT_NOW(a_load_only_when_free, load_i, buf_ready_o)
  `JASD_ASSERT_NEXT(a_drain_step, (rem_r > 3'd1) && out_ready, rem_r == $past(rem_r) - 3'd1)
  `JASD_ASSERT_NOW(a_ctrl_byte_zero, out_valid && (out_result_kind != KIND_DATA), out_byte == 8'd0)

endmodule

[rtl/core/json_answer_string_decoder.sv]
// Answer string decoder: finds the "answer" key in a reply byte stream and
// emits the unescaped, utf-8 encoded string value.
// Input channel: in_valid/in_ready with in_byte and in_new_reply; a set
// in_new_reply clears all parser state before that byte is handled.
// Result channel: out_valid/out_ready with out_result_kind (data, value
// opened, value complete, error), out_byte and out_last_of_run, which marks
// the final result caused by one input item.
// Each item is held in an input register, decoded in one pass against the
// parser state and written as a bundle of up to four results into the
// result register. Throughput is one item per cycle while out_ready is high
// and each item causes at most one result; an item causing more results,
// such as a \u escape that expands to more than one utf-8 byte, holds the
// result register until its last is taken. Items causing no result never occupy it.
// When the receiver stalls, the result register holds and in_ready drops
// once the input register is full as well.
// Reset (synchronous, active low) empties both registers and returns the
// parser to key search.
`timescale 1ns / 1ps

module json_answer_string_decoder import jasd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_new_reply,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_new_r;
  logic       buf_ready;
  logic       adv;
  bundle_t    bundle;

  assign adv      = stg_v_r && buf_ready;
  assign in_ready = !stg_v_r || buf_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_v_r <= 1'b1;
    end else if (adv) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_byte;
      stg_new_r  <= in_new_reply;
    end
  end

  // decode against parser state
  jasd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv_i       (adv),
    .byte_i      (stg_byte_r),
    .new_reply_i (stg_new_r),
    .bundle_o    (bundle)
  );

  // result register and serializer
  jasd_out_buf u_out_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_i          (adv),
    .bundle_i        (bundle),
    .buf_ready_o     (buf_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[test/json_answer_string_decoder_tb.sv]
// self-checking testbench of the json answer string decoder
`timescale 1ns / 1ps

module json_answer_string_decoder_tb;
  import jasd_pkg::*;

  localparam int          CycleLimit  = 200000;
  localparam int          RandomItems = 220;
  localparam int          MostResults = 4;
  localparam logic [63:0] AnswerKey   = "\"answer\"";

  typedef struct packed {
    logic [7:0] b;
    logic       nr;
  } reply_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_new_reply = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  // pending reply bytes, expected decoded results, results of one byte
  reply_item_t reply_q[$];
  decoded_t    decoded_q[$];
  decoded_t    burst_q[$];
  reply_item_t next_item;
  decoded_t    want;

  // decoder state as predicted
  phase_t      dec_phase = PH_SEARCH;
  logic [3:0]  key_pos = 4'd0;
  logic [1:0]  digit_cnt = 2'd0;
  logic [15:0] high_sur = 16'h0000;
  logic [15:0] unit_acc = 16'h0000;

  int fail_count = 0;
  int taken_n = 0;
  int reply_total = 0;
  int cycle_n = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit in_fire = 1'b0;

  json_answer_string_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_new_reply   (in_new_reply),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_kind(out_result_kind),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

  always #2 clk = ~clk;

  // json whitespace
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic void add_result(input kind_t k, input logic [7:0] v);
    decoded_t r;
    r.kind = k;
    r.data = (k == KIND_DATA) ? v : 8'h00;
    r.last = 1'b0;
    if (burst_q.size() < MostResults) burst_q.push_back(r);
  endfunction

  function automatic void reject_reply();
    add_result(KIND_ERR, 8'h00);
    dec_phase = PH_ERROR;
  endfunction

  // code point as 1 to 4 utf-8 bytes
  function automatic void push_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(KIND_DATA, cp[7:0]);
    end else if (cp < 21'h800) begin
      add_result(KIND_DATA, 8'hC0 | {3'b000, cp[10:6]});
      add_result(KIND_DATA, 8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_result(KIND_DATA, 8'hE0 | {4'b0000, cp[15:12]});
      add_result(KIND_DATA, 8'h80 | {2'b00, cp[11:6]});
      add_result(KIND_DATA, 8'h80 | {2'b00, cp[5:0]});
    end else if (cp <= 21'h10FFFF) begin
      add_result(KIND_DATA, 8'hF0 | {5'b00000, cp[20:18]});
      add_result(KIND_DATA, 8'h80 | {2'b00, cp[17:12]});
      add_result(KIND_DATA, 8'h80 | {2'b00, cp[11:6]});
      add_result(KIND_DATA, 8'h80 | {2'b00, cp[5:0]});
    end else begin
      reject_reply();
    end
  endfunction

  // predict the results of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic nr);
    int d;
    burst_q.delete();
    if (nr) begin
      dec_phase = PH_SEARCH;
      key_pos   = 4'd0;
      digit_cnt = 2'd0;
      high_sur  = 16'h0000;
      unit_acc  = 16'h0000;
    end
    case (dec_phase)
      PH_SEARCH: begin
        if (key_pos < 4'd8 && b == AnswerKey[63 - 8 * key_pos -: 8]) begin
          key_pos = key_pos + 4'd1;
          if (key_pos == 4'd8) begin
            key_pos   = 4'd0;
            dec_phase = PH_COLON;
          end
        end else begin
          key_pos = (b == CH_QUOTE) ? 4'd1 : 4'd0;
        end
      end
      PH_COLON: begin
        if (b == CH_COLON) dec_phase = PH_QUOTE;
        else if (!is_blank(b)) reject_reply();
      end
      PH_QUOTE: begin
        if (b == CH_QUOTE) begin
          add_result(KIND_OPEN, 8'h00);
          dec_phase = PH_VALUE;
        end else if (!is_blank(b)) begin
          reject_reply();
        end
      end
      PH_VALUE: begin
        if (b == CH_QUOTE) begin
          add_result(KIND_DONE, 8'h00);
          dec_phase = PH_DONE;
        end else if (b == CH_BSL) begin
          dec_phase = PH_ESC;
        end else if (b < 8'h20) begin
          reject_reply();
        end else begin
          add_result(KIND_DATA, b);
        end
      end
      PH_ESC: begin
        dec_phase = PH_VALUE;
        case (b)
          CH_QUOTE, CH_BSL, CH_SLASH: add_result(KIND_DATA, b);
          CH_B, CH_F: add_result(KIND_DATA, CH_SPACE);
          CH_N: add_result(KIND_DATA, CH_LF);
          CH_R: add_result(KIND_DATA, CH_CR);
          CH_T: add_result(KIND_DATA, CH_TAB);
          CH_U: begin
            digit_cnt = 2'd0;
            unit_acc  = 16'h0000;
            dec_phase = PH_HEX1;
          end
          default: reject_reply();
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
        else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h61 + 10;
        else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h41 + 10;
        else d = -1;
        if (d < 0) begin
          reject_reply();
        end else begin
          unit_acc = {unit_acc[11:0], d[3:0]};
          if (digit_cnt < 2'd3) begin
            digit_cnt = digit_cnt + 2'd1;
          end else begin
            digit_cnt = 2'd0;
            if (dec_phase == PH_HEX1) begin
              if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF) begin
                high_sur  = unit_acc;
                dec_phase = PH_PAIR_BS;
              end else if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF) begin
                reject_reply();
              end else begin
                dec_phase = PH_VALUE;
                push_utf8({5'b00000, unit_acc});
              end
            end else if (unit_acc < 16'hDC00 || unit_acc > 16'hDFFF) begin
              reject_reply();
            end else begin
              dec_phase = PH_VALUE;
              push_utf8({1'b0, high_sur[9:0], unit_acc[9:0]} + 21'h10000);
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (b == CH_BSL) dec_phase = PH_PAIR_U;
        else reject_reply();
      end
      PH_PAIR_U: begin
        if (b == CH_U) begin
          digit_cnt = 2'd0;
          unit_acc  = 16'h0000;
          dec_phase = PH_HEX2;
        end else begin
          reject_reply();
        end
      end
      default: ;
    endcase
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i]) decoded_q.push_back(burst_q[i]);
  endtask

  // stimulus builders
  task automatic send(input logic [7:0] b, input logic nr);
    reply_item_t it;
    it.b  = b;
    it.nr = nr;
    reply_q.push_back(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'b0000, n};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'b0000, n} - 8'd10;
  endfunction

  // range ends now and then, else anywhere in the range
  function automatic logic [15:0] pick_unit(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic send_unit(input logic [15:0] u);
    send(CH_BSL, 1'b0);
    send(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send(hex_char(u[4 * i +: 4]), 1'b0);
  endtask

  task automatic send_blank();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: send(CH_SPACE, 1'b0);
        1: send(CH_TAB, 1'b0);
        2: send(CH_CR, 1'b0);
        default: send(CH_LF, 1'b0);
      endcase
    end
  endtask

  // one piece of the answer value, mostly well formed
  task automatic send_piece();
    int         pick;
    logic [7:0] c;
    logic [15:0] u;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == CH_QUOTE || c == CH_BSL) c = 8'h78;
      send(c, 1'b0);
    end else if (pick < 48) begin
      send(8'($urandom_range(8'h7F, 8'hFF)), 1'b0);
    end else if (pick < 64) begin
      send(CH_BSL, 1'b0);
      case ($urandom_range(0, 7))
        0: send(CH_QUOTE, 1'b0);
        1: send(CH_BSL, 1'b0);
        2: send(CH_SLASH, 1'b0);
        3: send(CH_B, 1'b0);
        4: send(CH_F, 1'b0);
        5: send(CH_N, 1'b0);
        6: send(CH_R, 1'b0);
        default: send(CH_T, 1'b0);
      endcase
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: u = pick_unit(16'h0000, 16'h007F);
        1: u = pick_unit(16'h0080, 16'h07FF);
        2: u = pick_unit(16'h0800, 16'hD7FF);
        default: u = pick_unit(16'hE000, 16'hFFFF);
      endcase
      send_unit(u);
    end else if (pick < 91) begin
      send_unit(pick_unit(16'hD800, 16'hDBFF));
      send_unit(pick_unit(16'hDC00, 16'hDFFF));
    end else begin
      case ($urandom_range(0, 6))
        // raw control byte
        0: send(8'($urandom_range(8'h00, 8'h1F)), 1'b0);
        // unknown escape letter
        1: begin
          c = 8'($urandom_range(0, 255));
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: c = 8'h71;
            default: ;
          endcase
          send(CH_BSL, 1'b0);
          send(c, 1'b0);
        end
        // bad hex digit just outside the digit ranges
        2: begin
          send(CH_BSL, 1'b0);
          send(CH_U, 1'b0);
          repeat ($urandom_range(0, 3)) send(hex_char(4'($urandom_range(0, 15))), 1'b0);
          case ($urandom_range(0, 5))
            0: send(8'h2F, 1'b0);
            1: send(8'h3A, 1'b0);
            2: send(8'h40, 1'b0);
            3: send(8'h47, 1'b0);
            4: send(8'h60, 1'b0);
            default: send(8'h67, 1'b0);
          endcase
        end
        // lone low surrogate
        3: send_unit(pick_unit(16'hDC00, 16'hDFFF));
        // high surrogate without a following backslash
        4: begin
          send_unit(pick_unit(16'hD800, 16'hDBFF));
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == CH_BSL) c = 8'h78;
          send(c, 1'b0);
        end
        // high surrogate, backslash, then not u
        5: begin
          send_unit(pick_unit(16'hD800, 16'hDBFF));
          send(CH_BSL, 1'b0);
          c = 8'($urandom_range(0, 255));
          if (c == CH_U) c = 8'h6E;
          send(c, 1'b0);
        end
        // second unit outside the low surrogate range
        default: begin
          send_unit(pick_unit(16'hD800, 16'hDBFF));
          if ($urandom_range(0, 1)) send_unit(pick_unit(16'h0000, 16'hDBFF));
          else send_unit(pick_unit(16'hE000, 16'hFFFF));
        end
      endcase
    end
  endtask

  // one reply: either noise only, or optional noise, key, separators, value, trailing bytes
  task automatic send_reply();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send(8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(2, 8)) begin
        send(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
      return;
    end
    if (pick < 50) begin
      send(CH_QUOTE, 1'b1);
    end else begin
      send(8'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 1)) send_text("\"ans");
      repeat ($urandom_range(0, 3)) send(8'($urandom_range(0, 255)), 1'b0);
      send(CH_QUOTE, 1'b0);
    end
    send_text("answer\"");
    send_blank();
    if ($urandom_range(0, 99) < 4) send(8'($urandom_range(0, 255)), 1'b0);
    else send(CH_COLON, 1'b0);
    send_blank();
    if ($urandom_range(0, 99) < 4) send(8'($urandom_range(0, 255)), 1'b0);
    else send(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 6)) send_piece();
    if ($urandom_range(0, 9) != 0) begin
      send(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 2)) send(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // reply bytes into the block, result handshake readiness
  always @(negedge clk) begin
    if (taken_n < reply_total / 3) begin
      send_idle = 18;
      recv_idle = 71;
    end else if (taken_n < 2 * reply_total / 3) begin
      send_idle = 71;
      recv_idle = 18;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (rst_n && (!in_valid || in_fire)) begin
      if (reply_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        next_item = reply_q.pop_front();
        in_valid     <= 1'b1;
        in_byte      <= next_item.b;
        in_new_reply <= next_item.nr;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // check each result item, then predict from each accepted item
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("result with none expected: out_result_kind %0d out_byte %0h",
               out_result_kind, out_byte);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_result_kind !== want.kind) begin
          $error("out_result_kind expected %0d actual %0d", want.kind, out_result_kind);
          fail_count++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte expected %0h actual %0h", want.data, out_byte);
          fail_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("out_last_of_run expected %0b actual %0b", want.last, out_last_of_run);
          fail_count++;
        end
      end
    end
    if (in_fire) begin
      decode_byte(in_byte, in_new_reply);
      taken_n++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CycleLimit) begin
      $display("json_answer_string_decoder_tb failed");
      $finish;
    end
  end

  initial begin
    // directed reply: whitespace before and after colon, bytes FF and 7F, escaped nul,
    // completion, then a byte that is ignored
    send(CH_QUOTE, 1'b1);
    send_text("answer\"");
    send_text(" :\r\"");
    send(8'hFF, 1'b0);
    send(8'h7F, 1'b0);
    send_text("\\u0000");
    send(CH_QUOTE, 1'b0);
    send(8'h00, 1'b0);
    while (reply_q.size() < RandomItems) send_reply();
    reply_total = reply_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // drain: wait until all items are taken and all results seen
    while (reply_q.size() != 0 || in_valid) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("json_answer_string_decoder_tb passed");
    else $display("json_answer_string_decoder_tb failed");
    $finish;
  end

endmodule
